[rtl/core/gf256_field_arithmetic_defines.svh]
// assertion macros for the gf256 arithmetic block
`ifndef GF256_FIELD_ARITHMETIC_DEFINES_SVH
`define GF256_FIELD_ARITHMETIC_DEFINES_SVH

`ifndef SYNTHESIS
// checked property, quiet while reset is high
`define GFA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("gfa assertion failed");
// checked property, also checked during reset
`define GFA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gfa assertion failed");
`else
`define GFA_ASSERT(lbl, clk, rst, prop)
`define GFA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

[rtl/core/gfa_pkg.sv]
package gfa_pkg;

  localparam int unsigned ELEM_W     = 8;
  localparam int unsigned POLY_W     = 9;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned EXP_W      = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [KIND_W-1:0] KIND_ADD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MUL = 3'd1;
  localparam logic [KIND_W-1:0] KIND_INV = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POW = 3'd3;
  localparam logic [KIND_W-1:0] KIND_LOG = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_POLY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR  = 2'd1;

  localparam logic [POLY_W-1:0] FIELD_POLY_RESET = 9'h11D;
  localparam logic [ELEM_W-1:0] GENERATOR_RESET  = 8'd2;

  localparam logic [ELEM_W-1:0] GROUP_ORDER  = 8'd255;
  localparam logic [ELEM_W-1:0] LOG_ZERO     = 8'd255;
  localparam logic [ELEM_W-1:0] LOG_LAST_IDX = 8'd254;
  localparam logic [ELEM_W-1:0] INV_EXP      = 8'd254;

  typedef struct packed {
    logic [POLY_W-1:0] field_poly;
    logic [ELEM_W-1:0] generator;
  } gfa_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_LOG,
    ST_DONE
  } gfa_state_t;

endpackage

[rtl/core/gfa_mul.sv]
module gfa_mul (
  input  logic [gfa_pkg::POLY_W-1:0] poly,
  input  logic [gfa_pkg::ELEM_W-1:0] op_a,
  input  logic [gfa_pkg::ELEM_W-1:0] op_b,
  output logic [gfa_pkg::ELEM_W-1:0] prod
);
  import gfa_pkg::*;

  logic [ELEM_W-1:0] a;
  logic [POLY_W-1:0] sh;
  logic [ELEM_W-1:0] acc;

  // shift-and-add, reducing after each shift
  always_comb begin
    a   = op_a;
    acc = '0;
    sh  = '0;
    for (int k = 0; k < ELEM_W; k++) begin
      if (op_b[k]) begin
        acc = acc ^ a;
      end
      sh = {a, 1'b0};
      if (sh[POLY_W-1]) begin
        sh = sh ^ poly;
      end
      a = sh[ELEM_W-1:0];
    end
    prod = acc;
  end

endmodule

[rtl/core/gfa_core.sv]
`include "gf256_field_arithmetic_defines.svh"

module gfa_core (
  input  logic                        clk,
  input  logic                        rst,
  input  gfa_pkg::gfa_cfg_t           cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [gfa_pkg::KIND_W-1:0]  kind,
  input  logic [gfa_pkg::ELEM_W-1:0]  left_operand,
  input  logic [gfa_pkg::ELEM_W-1:0]  right_operand,
  input  logic [gfa_pkg::EXP_W-1:0]   exponent,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [gfa_pkg::ELEM_W-1:0]  res_data
);
  import gfa_pkg::*;

  gfa_state_t state, state_next;

  logic [ELEM_W-1:0] acc;
  logic [ELEM_W-1:0] base;
  logic [ELEM_W-1:0] n;
  logic [ELEM_W-1:0] idx;
  logic [ELEM_W-1:0] target;

  logic [ELEM_W-1:0] op_a;
  logic [ELEM_W-1:0] op_b;
  logic [ELEM_W-1:0] prod;

  logic              accept;
  logic [ELEM_W:0]   fold;
  logic [ELEM_W-1:0] exp_mod;
  logic [ELEM_W-1:0] n_shr;

  assign accept = in_valid && in_ready;
  assign n_shr  = {1'b0, n[ELEM_W-1:1]};

  // 256 = 1 mod 255, so fold bits 14:8 (the high byte without the sign bit) onto the low one
  always_comb begin
    fold = {2'b00, exponent[EXP_W-2:ELEM_W]} + {1'b0, exponent[ELEM_W-1:0]};
    if (fold >= {1'b0, GROUP_ORDER}) begin
      fold = fold - {1'b0, GROUP_ORDER};
    end
    exp_mod = fold[ELEM_W-1:0];
  end

  // operand steering into the shared multiplier
  assign op_a = (state == ST_POW_SQR) ? base : acc;
  assign op_b = (state == ST_LOG) ? cfg.generator : base;

  gfa_mul u_mul (
    .poly (cfg.field_poly),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (kind == KIND_MUL) begin
            state_next = ST_MUL;
          end else if (kind == KIND_INV && left_operand != '0) begin
            state_next = ST_POW_MUL;
          end else if (kind == KIND_POW && !exponent[EXP_W-1] && exp_mod != '0) begin
            state_next = ST_POW_MUL;
          end else if (kind == KIND_LOG && left_operand != '0) begin
            state_next = ST_LOG;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_MUL:     state_next = ST_DONE;
      ST_POW_MUL: state_next = ST_POW_SQR;
      ST_POW_SQR: begin
        if (n_shr == '0) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_POW_MUL;
        end
      end
      ST_LOG: begin
        if (acc == target || idx == LOG_LAST_IDX) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    res_valid = (state == ST_DONE);
    res_data  = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          idx    <= '0;
          target <= left_operand;
          unique case (kind)
            KIND_ADD: acc <= left_operand ^ right_operand;
            KIND_MUL: begin
              acc  <= left_operand;
              base <= right_operand;
            end
            KIND_INV: begin
              acc  <= (left_operand == '0) ? '0 : ELEM_W'(1);
              base <= left_operand;
              n    <= INV_EXP;
            end
            KIND_POW: begin
              acc  <= exponent[EXP_W-1] ? '0 : ELEM_W'(1);
              base <= cfg.generator;
              n    <= exp_mod;
            end
            KIND_LOG: acc <= (left_operand == '0) ? LOG_ZERO : ELEM_W'(1);
            default:  acc <= '0;
          endcase
        end
      end
      ST_MUL: acc <= prod;
      ST_POW_MUL: begin
        if (n[0]) begin
          acc <= prod;
        end
      end
      ST_POW_SQR: begin
        base <= prod;
        n    <= n_shr;
      end
      ST_LOG: begin
        // walk the powers of the generator until one matches, or give LOG_ZERO at the last index
        if (acc == target) begin
          acc <= idx;
        end else if (idx == LOG_LAST_IDX) begin
          acc <= LOG_ZERO;
        end else begin
          acc <= prod;
          idx <= idx + ELEM_W'(1);
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  `GFA_ASSERT(a_accept_leaves_idle, clk, rst, accept |=> state != ST_IDLE)
  `GFA_ASSERT(a_pow_count_live, clk, rst, (state == ST_POW_MUL || state == ST_POW_SQR) |-> n != '0)
  `GFA_ASSERT(a_res_held, clk, rst, res_valid && !res_ready |=> res_valid && $stable(res_data))
  `GFA_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> state == ST_IDLE)

endmodule

[rtl/core/gf256_field_arithmetic.sv]
// channel  handshake               payload
// cfg      cfg_valid / cfg_ready   cfg_index (0 field_poly, 1 generator), cfg_data
// in       in_valid / in_ready     kind, left_operand, right_operand, exponent
// out      out_valid / out_ready   result
//
// one shared gf multiplier does one product per cycle under a small sequencer;
// add goes straight to the result, multiply takes one product, power and inverse
// alternate multiply and square steps, log walks one generator step per cycle
// in_ready is high only while the sequencer is idle; a result may wait in the
// output register while the next beat is taken
// synchronous reset restores field_poly 0x11d and generator 2; cfg is always ready
module gf256_field_arithmetic (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gfa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gfa_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [gfa_pkg::KIND_W-1:0]      kind,
  input  logic [gfa_pkg::ELEM_W-1:0]      left_operand,
  input  logic [gfa_pkg::ELEM_W-1:0]      right_operand,
  input  logic signed [gfa_pkg::EXP_W-1:0] exponent,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gfa_pkg::ELEM_W-1:0]      result
);
  import gfa_pkg::*;

  gfa_cfg_t          cfg;
  logic              core_valid;
  logic              core_ready;
  logic [ELEM_W-1:0] core_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_poly <= FIELD_POLY_RESET;
      cfg.generator  <= GENERATOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_FIELD_POLY) begin
        cfg.field_poly <= cfg_data;
      end else if (cfg_index == REG_GENERATOR) begin
        cfg.generator <= cfg_data[ELEM_W-1:0];
      end
    end
  end

  gfa_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .left_operand  (left_operand),
    .right_operand (right_operand),
    .exponent      (exponent),
    .res_valid     (core_valid),
    .res_ready     (core_ready),
    .res_data      (core_data)
  );

  // output register, refilled in the same cycle it drains
  assign core_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_valid && core_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && core_ready) begin
      result <= core_data;
    end
  end

endmodule

[bench/gfa_result_checker.sv]
`timescale 1ns / 100ps
module gfa_result_checker
  import gfa_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic [KIND_W-1:0]        kind,
  input  logic [ELEM_W-1:0]        left_operand,
  input  logic [ELEM_W-1:0]        right_operand,
  input  logic signed [EXP_W-1:0]  exponent,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic [ELEM_W-1:0]        result,
  output int                       mismatches,
  output int                       results_owed,
  output int                       results_seen
);

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [ELEM_W-1:0] value;
  } field_answer_t;

  gfa_cfg_t      field_cfg;
  field_answer_t awaited_results[$];
  int            mismatch_cnt = 0;
  int            compare_cnt = 0;

  // shift-and-add product, reducing by the polynomial after every shift
  function automatic logic [ELEM_W-1:0] field_mul(input logic [ELEM_W-1:0] a,
                                                  input logic [ELEM_W-1:0] b,
                                                  input logic [POLY_W-1:0] poly);
    logic [POLY_W-1:0] sh;
    logic [ELEM_W-1:0] acc;
    sh = {1'b0, a};
    acc = '0;
    for (int k = 0; k < ELEM_W; k++) begin
      if (b[k]) acc ^= sh[ELEM_W-1:0];
      sh = {sh[ELEM_W-1:0], 1'b0};
      if (sh[POLY_W-1]) sh ^= poly;
      sh[POLY_W-1] = 1'b0;
    end
    return acc;
  endfunction

  function automatic logic [ELEM_W-1:0] field_pow(input logic [ELEM_W-1:0] base,
                                                  input int unsigned n,
                                                  input logic [POLY_W-1:0] poly);
    logic [ELEM_W-1:0] acc;
    acc = 8'd1;
    while (n != 0) begin
      if (n[0]) acc = field_mul(acc, base, poly);
      base = field_mul(base, base, poly);
      n = n >> 1;
    end
    return acc;
  endfunction

  // walk the powers of the generator; unreachable values fall out as log-of-zero
  function automatic logic [ELEM_W-1:0] field_log(input logic [ELEM_W-1:0] x,
                                                  input gfa_cfg_t c);
    logic [ELEM_W-1:0] p;
    if (x == '0) return LOG_ZERO;
    p = 8'd1;
    for (int i = 0; i < int'(GROUP_ORDER); i++) begin
      if (p == x) return ELEM_W'(i);
      p = field_mul(p, c.generator, c.field_poly);
    end
    return LOG_ZERO;
  endfunction

  function automatic logic [ELEM_W-1:0] field_op_result(input logic [KIND_W-1:0] k,
                                                        input logic [ELEM_W-1:0] a,
                                                        input logic [ELEM_W-1:0] b,
                                                        input logic [EXP_W-1:0] e,
                                                        input gfa_cfg_t c);
    int unsigned n;
    case (k)
      KIND_ADD: return a ^ b;
      KIND_MUL: return field_mul(a, b, c.field_poly);
      KIND_INV: return (a == '0) ? '0 : field_pow(a, int'(INV_EXP), c.field_poly);
      KIND_POW: begin
        if (e[EXP_W-1]) return '0;
        n = e;
        return field_pow(c.generator, n % int'(GROUP_ORDER), c.field_poly);
      end
      KIND_LOG: return field_log(a, c);
      default:  return '0;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    field_answer_t entry;
    if (rst) begin
      field_cfg.field_poly = FIELD_POLY_RESET;
      field_cfg.generator = GENERATOR_RESET;
      awaited_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FIELD_POLY: field_cfg.field_poly = cfg_data;
          REG_GENERATOR:  field_cfg.generator = cfg_data[ELEM_W-1:0];
          default: ;
        endcase
      end
      // retire the result beat before queuing a new operation at the same edge
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t unexpected result beat: expected none actual %02h", $time, result);
          mismatch_cnt++;
        end else begin
          entry = awaited_results.pop_front();
          compare_cnt++;
          if (result !== entry.value) begin
            $display("%0t result mismatch (kind %0d): expected %02h actual %02h",
                     $time, entry.kind, entry.value, result);
            mismatch_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        entry.kind = kind;
        entry.value = field_op_result(kind, left_operand, right_operand, exponent, field_cfg);
        awaited_results.push_back(entry);
      end
    end
    results_owed <= awaited_results.size();
    mismatches <= mismatch_cnt;
    results_seen <= compare_cnt;
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
module testbench;
  import gfa_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam logic [KIND_W-1:0]    KIND_SPARE_A = 3'd5;
  localparam logic [KIND_W-1:0]    KIND_SPARE_B = 3'd6;
  localparam logic [KIND_W-1:0]    KIND_SPARE_C = 3'd7;
  localparam int                   OPS_PER_SETTING = 312;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_ready;
  logic [KIND_W-1:0]       kind;
  logic [ELEM_W-1:0]       left_operand;
  logic [ELEM_W-1:0]       right_operand;
  logic signed [EXP_W-1:0] exponent;
  logic                    out_valid;
  logic                    out_ready;
  logic [ELEM_W-1:0]       result;

  int mismatches;
  int results_owed;
  int results_seen;
  bit quiet;
  int ops_sent = 0;
  int settings_run = 1;

  always #5 clk = ~clk;

  gf256_field_arithmetic dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .left_operand(left_operand),
    .right_operand(right_operand), .exponent(exponent),
    .out_valid(out_valid), .out_ready(out_ready), .result(result)
  );

  gfa_result_checker result_check (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .kind(kind), .left_operand(left_operand),
    .right_operand(right_operand), .exponent(exponent),
    .out_valid(out_valid), .out_ready(out_ready), .result(result),
    .mismatches(mismatches), .results_owed(results_owed), .results_seen(results_seen)
  );

  initial begin : watchdog
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_elem();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'hFF;
      default: return ELEM_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic signed [EXP_W-1:0] pick_exponent();
    case ($urandom_range(0, 3))
      0:       return EXP_W'($urandom_range(0, 600));
      1:       return EXP_W'(int'(GROUP_ORDER) * $urandom_range(0, 128) + $urandom_range(0, 2));
      default: return EXP_W'($urandom());
    endcase
  endfunction

  task automatic send_op(input logic [KIND_W-1:0] k, input logic [ELEM_W-1:0] a,
                         input logic [ELEM_W-1:0] b, input logic [EXP_W-1:0] e);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    left_operand <= a;
    right_operand <= b;
    exponent <= e;
    do @(posedge clk); while (!in_ready);
    ops_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // leaves cfg_valid high so back-to-back writes need no second assignment per edge
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_setting(input logic [CFG_DATA_W-1:0] poly,
                               input logic [CFG_DATA_W-1:0] gen_data, input bit spare_too);
    drain_results();
    write_reg(REG_FIELD_POLY, poly);
    if (spare_too) begin
      write_reg(REG_SPARE_LO, 9'h0AA);
      write_reg(REG_SPARE_HI, 9'h155);
    end
    write_reg(REG_GENERATOR, gen_data);
    cfg_valid <= 1'b0;
    settings_run++;
  endtask

  task automatic random_ops(input int count);
    logic [KIND_W-1:0] k;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == count / 2) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 15)      k = KIND_ADD;
      else if (pick < 40) k = KIND_MUL;
      else if (pick < 55) k = KIND_INV;
      else if (pick < 75) k = KIND_POW;
      else if (pick < 95) k = KIND_LOG;
      else begin
        case ($urandom_range(0, 2))
          0:       k = KIND_SPARE_A;
          1:       k = KIND_SPARE_B;
          default: k = KIND_SPARE_C;
        endcase
      end
      send_op(k, pick_elem(), pick_elem(), pick_exponent());
    end
    quiet = 1'b0;
  endtask

  initial begin : response_side
    out_ready = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      int unsigned stall;
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : stimulus
    int waited;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_FIELD_POLY;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = KIND_ADD;
    left_operand = '0;
    right_operand = '0;
    exponent = '0;
    quiet = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // field extremes under the reset polynomial and generator
    send_op(KIND_ADD, 8'h00, 8'h00, 16'h0000);
    send_op(KIND_ADD, 8'hA5, 8'h5A, 16'hFFFF);
    send_op(KIND_ADD, 8'hFF, 8'hFF, 16'h1234);
    send_op(KIND_MUL, 8'h00, 8'h7F, 16'h0000);
    send_op(KIND_MUL, 8'h9C, 8'h00, 16'h0000);
    send_op(KIND_MUL, 8'hFF, 8'hFF, 16'h0000);
    send_op(KIND_MUL, 8'h80, 8'h02, 16'h0000);
    send_op(KIND_INV, 8'h00, 8'h33, 16'h0000);
    send_op(KIND_INV, 8'h01, 8'h00, 16'h0000);
    send_op(KIND_INV, 8'hFF, 8'h00, 16'h0000);
    send_op(KIND_INV, 8'h53, 8'h00, 16'h0000);
    send_op(KIND_POW, 8'h00, 8'h00, 16'h0000);
    send_op(KIND_POW, 8'h00, 8'h00, 16'h00FE);
    send_op(KIND_POW, 8'h00, 8'h00, 16'h00FF);
    send_op(KIND_POW, 8'h00, 8'h00, 16'h0100);
    send_op(KIND_POW, 8'hFF, 8'hFF, 16'h7FFF);
    send_op(KIND_POW, 8'h00, 8'h00, 16'hFFFF);
    send_op(KIND_POW, 8'h00, 8'h00, 16'h8000);
    send_op(KIND_LOG, 8'h00, 8'h00, 16'h0000);
    send_op(KIND_LOG, 8'h01, 8'h00, 16'h0000);
    send_op(KIND_LOG, 8'h02, 8'h00, 16'h0000);
    send_op(KIND_LOG, 8'hFF, 8'h00, 16'h0000);
    send_op(KIND_SPARE_A, 8'hFF, 8'hFF, 16'h7FFF);
    send_op(KIND_SPARE_B, 8'h12, 8'h34, 16'h0005);
    send_op(KIND_SPARE_C, 8'h80, 8'h01, 16'hFFFF);

    random_ops(OPS_PER_SETTING);
    apply_setting(9'h11B, 9'h003, 1'b0);
    random_ops(OPS_PER_SETTING);
    // lowest polynomial and unit generator: log only reaches one
    apply_setting(9'h100, 9'h001, 1'b1);
    random_ops(OPS_PER_SETTING);
    apply_setting(9'h1FF, 9'h0FF, 1'b0);
    random_ops(OPS_PER_SETTING);
    // generator data with bit 8 set, which the register drops
    apply_setting(9'h187, 9'h1F3, 1'b0);
    random_ops(OPS_PER_SETTING);
    apply_setting(FIELD_POLY_RESET, 9'h102, 1'b0);
    random_ops(OPS_PER_SETTING);

    in_valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (results_owed != 0 && waited < 5000);
    repeat (300) @(posedge clk);

    $display("ran %0d field operations across %0d polynomial/generator settings",
             ops_sent, settings_run);
    $display("%0d results compared, %0d mismatched, %0d still owed",
             results_seen, mismatches, results_owed);
    if (mismatches == 0 && results_owed == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
